/* rtl/core/source_tokenizer_defines.svh */
// Assertion macros for the source tokenizer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/st_pkg.sv */
// Package for the source tokenizer: position width, lexer modes,
// token kinds, error codes, result type, character class and saturating position helpers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package st_pkg;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam int MAX_RES = 3;

    // Lexer modes
    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_ZERO     = 4'd2;
    localparam logic [3:0] M_DEC      = 4'd3;
    localparam logic [3:0] M_DECDOT   = 4'd4;
    localparam logic [3:0] M_FLOATEND = 4'd5;
    localparam logic [3:0] M_HEX      = 4'd6;
    localparam logic [3:0] M_BIN      = 4'd7;
    localparam logic [3:0] M_STRING   = 4'd8;
    localparam logic [3:0] M_LINECMT  = 4'd9;
    localparam logic [3:0] M_BLOCKCMT = 4'd10;

    // Token kinds
    localparam logic [3:0] K_IDENT  = 4'd0;
    localparam logic [3:0] K_OP     = 4'd1;
    localparam logic [3:0] K_CURLY  = 4'd2;
    localparam logic [3:0] K_PAREN  = 4'd3;
    localparam logic [3:0] K_SQUARE = 4'd4;
    localparam logic [3:0] K_BREAK  = 4'd5;
    localparam logic [3:0] K_STRING = 4'd6;
    localparam logic [3:0] K_CHAR   = 4'd7;
    localparam logic [3:0] K_INT    = 4'd8;
    localparam logic [3:0] K_DOUBLE = 4'd9;
    localparam logic [3:0] K_FLOAT  = 4'd10;
    localparam logic [3:0] K_HEX    = 4'd11;
    localparam logic [3:0] K_BIN    = 4'd12;
    localparam logic [3:0] K_LCMT   = 4'd13;
    localparam logic [3:0] K_BCMT   = 4'd14;

    // Error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_STRING   = 3'd2;
    localparam logic [2:0] E_COMMENT  = 3'd3;
    localparam logic [2:0] E_DOTS     = 3'd4;
    localparam logic [2:0] E_JUNK     = 3'd5;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] kind;
        pos_t       start;
        pos_t       length;
        pos_t       line;
        pos_t       column;
        logic [2:0] err;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == 8'h2B || c == 8'h2A || c == 8'h21 || c == 8'h26 ||
               (c >= 8'h2D && c <= 8'h2F) || c == 8'h25 || c == 8'h5E ||
               (c >= 8'h3C && c <= 8'h40) || c == 8'h7E || c == 8'h7C;
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c == 8'h7B || c == 8'h28 || c == 8'h5B ||
               c == 8'h7D || c == 8'h29 || c == 8'h5D;
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return c == 8'h27 || c == 8'h22;
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return c == 8'h2C || c == 8'h3B;
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_space(c) || is_op(c) || is_bracket(c) || is_quote(c) || is_break(c);
    endfunction

    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? POS_MAX : v + pos_t'(1);
    endfunction

    function automatic pos_t sat_dec(input pos_t v);
        pos_t r;
        if (v == POS_MAX)
            r = POS_MAX;
        else if (v == '0)
            r = '0;
        else
            r = v - pos_t'(1);
        return r;
    endfunction

    function automatic pos_t span(input pos_t e, input pos_t s);
        return (e > s) ? e - s : '0;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/st_lexer.sv */
// Lexer state registers and the per-byte next-state and token logic.
// Depends on st_pkg.
`timescale 1ns / 1ps
`default_nettype none

module st_lexer
    import st_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_code,
    input  wire logic       eos,
    output result_t         res [MAX_RES],
    output logic [1:0]      res_cnt
);

    logic [3:0] mode_reg, mode_next;
    pos_t so_reg, so_next, cur_reg, cur_next, line_reg, line_next, col_reg, col_next;
    pos_t sl_reg, sl_next, sc_reg, sc_next;
    logic qd_reg, qd_next, esc_reg, esc_next, cm_reg, cm_next;
    logic sp_reg, sp_next, err_reg, err_next;
    logic [1:0] dot_reg, dot_next;

    function automatic result_t mk(input logic v, input logic [3:0] k, input pos_t s,
                                   input pos_t l, input pos_t ln, input pos_t cl,
                                   input logic [2:0] e);
        result_t r;
        r.valid = v; r.kind = k; r.start = s; r.length = l;
        r.line = ln; r.column = cl; r.err = e;
        return r;
    endfunction

    // Walk one byte through the lexer: main step, decimal step, number end,
    // idle dispatch, end-of-source flush, position advance and the final-byte reset.
    always_comb
    begin
        logic do_idle, do_dec, do_fin;
        logic [3:0] fin_kind;
        logic [1:0] n;
        result_t item;
        pos_t dotp;
        pos_t flen;
        do_idle = 1'b0; do_dec = 1'b0; do_fin = 1'b0;
        fin_kind = K_INT; n = 2'd0; dotp = '0; flen = '0;
        item = '0;
        for (int i = 0; i < MAX_RES; i++)
            res[i] = '0;
        mode_next = mode_reg; so_next = so_reg; cur_next = cur_reg;
        line_next = line_reg; col_next = col_reg; sl_next = sl_reg; sc_next = sc_reg;
        qd_next = qd_reg; esc_next = esc_reg; cm_next = cm_reg; sp_next = sp_reg;
        err_next = err_reg; dot_next = dot_reg;

        if (!err_reg)
        begin
            if (sp_reg)
            begin
                sp_next = 1'b0;
                if (char_code == 8'h2F || char_code == 8'h2A)
                begin
                    so_next = sat_inc(cur_reg);
                    cm_next = 1'b0;
                    mode_next = (char_code == 8'h2F) ? M_LINECMT : M_BLOCKCMT;
                end
                else
                begin
                    item = mk(1'b1, K_OP, so_next, pos_t'(1), sl_next, sc_next, E_NONE);
                    if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                    do_idle = 1'b1;
                end
            end
            else
            begin
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        if (is_term(char_code))
                        begin
                            item = mk(1'b1, K_IDENT, so_next, span(cur_reg, so_next),
                                      sl_next, sc_next, E_NONE);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    M_ZERO:
                    begin
                        if (char_code == 8'h78 || char_code == 8'h58 ||
                            char_code == 8'h62 || char_code == 8'h42)
                        begin
                            so_next = sat_inc(cur_reg);
                            mode_next = (char_code == 8'h78 || char_code == 8'h58) ?
                                        M_HEX : M_BIN;
                        end
                        else
                        begin
                            mode_next = M_DEC;
                            do_dec = 1'b1;
                        end
                    end
                    M_DEC:
                        do_dec = 1'b1;
                    M_DECDOT:
                    begin
                        if (char_code == 8'h2E)
                        begin
                            dotp = sat_dec(cur_reg);
                            item = mk(1'b1, (dot_next > 2'd1) ? K_DOUBLE : K_INT, so_next,
                                      span(dotp, so_next), sl_next, sc_next, E_NONE);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            item = mk(1'b1, K_OP, dotp, pos_t'(1), line_reg,
                                      sat_dec(col_reg), E_NONE);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                        else if (dot_next > 2'd1)
                        begin
                            item = mk(1'b0, K_IDENT, '0, '0, line_reg, col_reg, E_DOTS);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            err_next = 1'b1; mode_next = M_IDLE; sp_next = 1'b0;
                        end
                        else
                        begin
                            mode_next = M_DEC;
                            do_dec = 1'b1;
                        end
                    end
                    M_FLOATEND:
                    begin
                        mode_next = M_IDLE;
                        if (is_term(char_code))
                            do_idle = 1'b1;
                        else
                        begin
                            item = mk(1'b0, K_IDENT, '0, '0, line_reg, col_reg, E_JUNK);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            err_next = 1'b1; sp_next = 1'b0;
                        end
                    end
                    M_HEX:
                    begin
                        if (!is_hex(char_code))
                        begin
                            do_fin = 1'b1; fin_kind = K_HEX;
                        end
                    end
                    M_BIN:
                    begin
                        if (char_code != 8'h30 && char_code != 8'h31)
                        begin
                            do_fin = 1'b1; fin_kind = K_BIN;
                        end
                    end
                    M_STRING:
                    begin
                        if (char_code == 8'h0A || char_code == 8'h00)
                        begin
                            item = mk(1'b0, K_IDENT, '0, '0, line_reg, col_reg, E_STRING);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            err_next = 1'b1; mode_next = M_IDLE; sp_next = 1'b0;
                        end
                        else if (char_code == (qd_reg ? 8'h22 : 8'h27) && !esc_reg)
                        begin
                            item = mk(1'b1, qd_reg ? K_STRING : K_CHAR, so_next,
                                      span(cur_reg, so_next), sl_next, sc_next, E_NONE);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            mode_next = M_IDLE;
                        end
                        else
                            esc_next = (char_code == 8'h5C) ? ~esc_reg : 1'b0;
                    end
                    M_LINECMT:
                    begin
                        if (char_code == 8'h0A)
                        begin
                            item = mk(1'b1, K_LCMT, so_next, span(cur_reg, so_next),
                                      sl_next, sc_next, E_NONE);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            mode_next = M_IDLE;
                        end
                    end
                    M_BLOCKCMT:
                    begin
                        if (cm_reg && char_code == 8'h2F)
                        begin
                            item = mk(1'b1, K_BCMT, so_next, span(sat_dec(cur_reg), so_next),
                                      sl_next, sc_next, E_NONE);
                            if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                            cm_next = 1'b0;
                            mode_next = M_IDLE;
                        end
                        else
                            cm_next = (char_code == 8'h2A);
                    end
                    default:
                    begin
                        mode_next = M_IDLE;
                        do_idle = 1'b1;
                    end
                endcase
            end

            // Decimal digits, dots and the float suffix.
            if (do_dec)
            begin
                if (is_digit(char_code))
                    do_dec = 1'b0;
                else if (char_code == 8'h2E)
                begin
                    if (dot_next != 2'd3)
                        dot_next = dot_next + 2'd1;
                    mode_next = M_DECDOT;
                end
                else if (char_code == 8'h66 || char_code == 8'h46)
                begin
                    item = mk(1'b1, K_FLOAT, so_next, span(cur_reg, so_next),
                              sl_next, sc_next, E_NONE);
                    if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                    mode_next = M_FLOATEND;
                end
                else
                begin
                    do_fin = 1'b1;
                    fin_kind = (dot_next != 2'd0) ? K_DOUBLE : K_INT;
                end
            end

            // A number ends; a byte that is not a terminator raises a junk error.
            if (do_fin)
            begin
                item = mk(1'b1, fin_kind, so_next, span(cur_reg, so_next),
                          sl_next, sc_next, E_NONE);
                if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                mode_next = M_IDLE;
                if (is_term(char_code))
                    do_idle = 1'b1;
                else
                begin
                    item = mk(1'b0, K_IDENT, '0, '0, line_reg, col_reg, E_JUNK);
                    if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                    err_next = 1'b1; sp_next = 1'b0;
                end
            end

            // Idle dispatch: start a token or report a one-byte token.
            if (do_idle && !is_space(char_code))
            begin
                if (is_quote(char_code))
                begin
                    sl_next = line_reg; sc_next = col_reg;
                    so_next = sat_inc(cur_reg);
                    qd_next = (char_code == 8'h22);
                    esc_next = 1'b0;
                    mode_next = M_STRING;
                end
                else if (is_bracket(char_code) || is_break(char_code) ||
                         (is_op(char_code) && char_code != 8'h2F))
                begin
                    if (char_code == 8'h7B || char_code == 8'h7D)
                        item.kind = K_CURLY;
                    item = mk(1'b1,
                              is_break(char_code) ? K_BREAK :
                              (char_code == 8'h7B || char_code == 8'h7D) ? K_CURLY :
                              (char_code == 8'h28 || char_code == 8'h29) ? K_PAREN :
                              is_bracket(char_code) ? K_SQUARE : K_OP,
                              cur_reg, pos_t'(1), line_reg, col_reg, E_NONE);
                    if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                end
                else if (char_code == 8'h2F)
                begin
                    so_next = cur_reg; sl_next = line_reg; sc_next = col_reg;
                    sp_next = 1'b1;
                end
                else if (is_digit(char_code))
                begin
                    so_next = cur_reg; sl_next = line_reg; sc_next = col_reg;
                    dot_next = 2'd0;
                    mode_next = (char_code == 8'h30) ? M_ZERO : M_DEC;
                end
                else
                begin
                    so_next = cur_reg; sl_next = line_reg; sc_next = col_reg;
                    mode_next = M_IDENT;
                end
            end

            // End of source flushes any open token.
            if (eos && !err_next)
            begin
                flen = span(sat_inc(cur_reg), so_next);
                if (sp_next)
                begin
                    item = mk(1'b1, K_OP, so_next, pos_t'(1), sl_next, sc_next, E_NONE);
                    if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                end
                unique case (mode_next)
                    M_IDENT, M_ZERO, M_DEC, M_HEX, M_BIN, M_LINECMT:
                    begin
                        item = mk(1'b1,
                                  (mode_next == M_IDENT) ? K_IDENT :
                                  (mode_next == M_HEX) ? K_HEX :
                                  (mode_next == M_BIN) ? K_BIN :
                                  (mode_next == M_LINECMT) ? K_LCMT :
                                  (dot_next != 2'd0) ? K_DOUBLE : K_INT,
                                  so_next, flen, sl_next, sc_next, E_NONE);
                        if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                    end
                    M_DECDOT:
                    begin
                        if (dot_next > 2'd1)
                            item = mk(1'b0, K_IDENT, '0, '0, line_reg, col_reg, E_DOTS);
                        else
                            item = mk(1'b1, K_DOUBLE, so_next, flen, sl_next, sc_next,
                                      E_NONE);
                        if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                    end
                    M_BLOCKCMT, M_STRING:
                    begin
                        item = mk(1'b0, K_IDENT, '0, '0, line_reg, col_reg,
                                  (mode_next == M_STRING) ? E_STRING : E_COMMENT);
                        if (n != 2'd3) begin res[n] = item; n = n + 2'd1; end
                    end
                    default:
                        do_idle = 1'b0;
                endcase
            end

            // Advance the position.
            cur_next = sat_inc(cur_reg);
            if (char_code == 8'h0A)
            begin
                line_next = sat_inc(line_reg);
                col_next = pos_t'(1);
            end
            else
                col_next = sat_inc(col_reg);
        end

        // The final byte returns everything to the reset state.
        if (eos)
        begin
            mode_next = M_IDLE; so_next = '0; cur_next = '0;
            line_next = pos_t'(1); col_next = pos_t'(1);
            sl_next = pos_t'(1); sc_next = pos_t'(1);
            qd_next = 1'b0; esc_next = 1'b0; cm_next = 1'b0;
            sp_next = 1'b0; err_next = 1'b0; dot_next = 2'd0;
        end
        res_cnt = n;
    end

    // State registers, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; so_reg <= '0; cur_reg <= '0;
            line_reg <= pos_t'(1); col_reg <= pos_t'(1);
            sl_reg <= pos_t'(1); sc_reg <= pos_t'(1);
            qd_reg <= 1'b0; esc_reg <= 1'b0; cm_reg <= 1'b0;
            sp_reg <= 1'b0; err_reg <= 1'b0; dot_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next; so_reg <= so_next; cur_reg <= cur_next;
            line_reg <= line_next; col_reg <= col_next;
            sl_reg <= sl_next; sc_reg <= sc_next;
            qd_reg <= qd_next; esc_reg <= esc_next; cm_reg <= cm_next;
            sp_reg <= sp_next; err_reg <= err_next; dot_reg <= dot_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/st_outq.sv */
// Result register bank: holds the results of one byte and hands them out one
// transaction per cycle while out_ready is high. Depends on st_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "source_tokenizer_defines.svh"

module st_outq
    import st_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire result_t    res_in [MAX_RES],
    input  wire logic [1:0] cnt_in,
    output logic            load_ok,
    output logic            out_valid,
    input  wire logic       out_ready,
    output result_t         out_res,
    output logic            out_last
);

    result_t    res_reg [MAX_RES];
    logic [1:0] cnt_reg, idx_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = res_reg[idx_reg];
    assign out_last  = (idx_reg == cnt_reg - 2'd1);
    assign pop       = out_valid && out_ready;
    assign load_ok   = !out_valid || (pop && out_last);

    // Result payload, loaded per accepted byte.
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    // Fill count and read index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= cnt_in;
            idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            if (out_last)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    `ST_ASSERT_SAME(a_idx_in_range, out_valid, idx_reg < cnt_reg, "read index past fill count")
    `ST_ASSERT_SAME(a_no_overwrite, load, load_ok, "results overwritten before delivery")
    `ST_ASSERT_NEXT(a_step, pop && !out_last && !load, idx_reg == $past(idx_reg) + 2'd1,
                    "read index did not advance")

endmodule

`default_nettype wire

/* rtl/core/source_tokenizer.sv */
// Top level of the streaming source tokenizer.
// The first result of a byte is offered in the cycle after its transaction.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready
// is high; a byte with more results (up to 3) holds the next byte until the bank drains.
// Reset: rst_n clears the lexer to idle at line 1, column 1, offset 0,
// and empties the result bank.
`timescale 1ns / 1ps
`default_nettype none

module source_tokenizer
    import st_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // token_start, token_length, token_line,
                                        // token_column, error_code, zero fill
    output logic [4:0]       m_tuser,   // token_valid, token_kind[3:0]
    output logic             m_tlast    // last_in_run
);

    result_t    lex_res [MAX_RES];
    logic [1:0] lex_cnt;
    logic       accept;
    result_t    out_res;

    assign accept = s_tvalid && s_tready;

    st_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_tdata),
        .eos       (s_tlast),
        .res       (lex_res),
        .res_cnt   (lex_cnt)
    );

    st_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (lex_res),
        .cnt_in    (lex_cnt),
        .load_ok   (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    // Pack one result transaction.
    assign m_tdata = {5'd0, out_res.err, 16'(out_res.column), 16'(out_res.line),
                      16'(out_res.length), 16'(out_res.start)};
    assign m_tuser = {out_res.kind, out_res.valid};

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the source_tokenizer streaming lexer.
// It feeds byte sources, predicts every token and error report, and checks each result.
// Depends on st_pkg and the source_tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
    import st_pkg::*;

    localparam int LIMIT_CYCLES = 20000;

    typedef struct {
        logic [7:0] code;
        logic       eos;
    } src_byte_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] kind;
        pos_t       start;
        pos_t       length;
        pos_t       line;
        pos_t       column;
        logic [2:0] err;
        logic       last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    source_tokenizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    src_byte_t pending_bytes[$];
    token_t    token_q[$];
    int        errors;
    int        cycles;
    int        sent;
    int        tokens_seen;
    int        sources;
    bit        stim_done;
    bit        paused;
    bit        byte_taken;

    // Lexer state of the predictor.
    logic [3:0] lx_mode;
    pos_t       lx_start, lx_off, lx_line, lx_col, lx_sline, lx_scol;
    logic       lx_dq, lx_esc, lx_slash, lx_err;
    logic [1:0] lx_dots, lx_close;
    int         lx_nres;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Character classes.
    function automatic bit ch_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit ch_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit ch_hex(logic [7:0] c);
        return ch_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic bit ch_op(logic [7:0] c);
        return c == "+" || c == "*" || c == "!" || c == "&" || (c >= "-" && c <= "/") ||
               c == "%" || c == "^" || (c >= "<" && c <= "@") || c == "~" || c == "|";
    endfunction
    function automatic bit ch_bracket(logic [7:0] c);
        return c == "{" || c == "(" || c == "[" || c == "}" || c == ")" || c == "]";
    endfunction
    function automatic bit ch_quote(logic [7:0] c);
        return c == 8'h27 || c == 8'h22;
    endfunction
    function automatic bit ch_break(logic [7:0] c);
        return c == "," || c == ";";
    endfunction
    function automatic bit ch_term(logic [7:0] c);
        return ch_space(c) || ch_op(c) || ch_bracket(c) || ch_quote(c) || ch_break(c);
    endfunction
    function automatic pos_t up_sat(pos_t v);
        return (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction
    function automatic pos_t down_sat(pos_t v);
        if (v == POS_MAX)
            return POS_MAX;
        return (v == 0) ? pos_t'(0) : v - 1'b1;
    endfunction
    function automatic pos_t gap(pos_t e, pos_t s);
        return (e > s) ? e - s : pos_t'(0);
    endfunction

    task automatic clear_lexer();
        lx_mode = M_IDLE;
        lx_start = 0; lx_off = 0;
        lx_line = 1; lx_col = 1; lx_sline = 1; lx_scol = 1;
        lx_dq = 0; lx_esc = 0; lx_dots = 0; lx_close = 0;
        lx_slash = 0; lx_err = 0;
    endtask

    task automatic push_token(logic v, logic [3:0] k, pos_t st, pos_t len,
                              pos_t ln, pos_t col, logic [2:0] e);
        token_t t;
        if (lx_nres >= MAX_RES)
            return;
        t = '{v, k, st, len, ln, col, e, 1'b0};
        token_q.insert(token_q.size(), t);
        lx_nres++;
    endtask

    task automatic push_open(logic [3:0] k, pos_t len);
        push_token(1'b1, k, lx_start, len, lx_sline, lx_scol, E_NONE);
    endtask

    task automatic raise_error(logic [2:0] e);
        push_token(1'b0, K_IDENT, 0, 0, lx_line, lx_col, e);
        lx_err = 1;
        lx_mode = M_IDLE;
        lx_slash = 0;
    endtask

    task automatic open_here();
        lx_start = lx_off;
        lx_sline = lx_line;
        lx_scol = lx_col;
    endtask

    // Start of a new token from the idle mode.
    task automatic begin_token(logic [7:0] c);
        if (ch_space(c))
            return;
        if (ch_quote(c))
        begin
            open_here();
            lx_start = up_sat(lx_off);
            lx_dq = (c == 8'h22);
            lx_esc = 0;
            lx_mode = M_STRING;
        end
        else if (ch_bracket(c))
            push_token(1'b1, (c == "{" || c == "}") ? K_CURLY :
                       (c == "(" || c == ")") ? K_PAREN : K_SQUARE,
                       lx_off, 1, lx_line, lx_col, E_NONE);
        else if (ch_break(c))
            push_token(1'b1, K_BREAK, lx_off, 1, lx_line, lx_col, E_NONE);
        else if (c == "/")
        begin
            open_here();
            lx_slash = 1;
        end
        else if (ch_op(c))
            push_token(1'b1, K_OP, lx_off, 1, lx_line, lx_col, E_NONE);
        else if (ch_digit(c))
        begin
            open_here();
            lx_dots = 0;
            lx_mode = (c == "0") ? M_ZERO : M_DEC;
        end
        else
        begin
            open_here();
            lx_mode = M_IDENT;
        end
    endtask

    task automatic close_number(logic [3:0] k, logic [7:0] c);
        push_open(k, gap(lx_off, lx_start));
        lx_mode = M_IDLE;
        if (ch_term(c))
            begin_token(c);
        else
            raise_error(E_JUNK);
    endtask

    task automatic in_decimal(logic [7:0] c);
        if (ch_digit(c))
            return;
        if (c == ".")
        begin
            if (lx_dots < 3)
                lx_dots++;
            lx_mode = M_DECDOT;
        end
        else if (c == "f" || c == "F")
        begin
            push_open(K_FLOAT, gap(lx_off, lx_start));
            lx_mode = M_FLOATEND;
        end
        else
            close_number((lx_dots != 0) ? K_DOUBLE : K_INT, c);
    endtask

    task automatic lex_byte(logic [7:0] c);
        pos_t dot;
        if (lx_slash)
        begin
            lx_slash = 0;
            if (c == "/" || c == "*")
            begin
                lx_start = up_sat(lx_off);
                lx_close = 0;
                lx_mode = (c == "/") ? M_LINECMT : M_BLOCKCMT;
            end
            else
            begin
                push_open(K_OP, 1);
                begin_token(c);
            end
            return;
        end
        case (lx_mode)
            M_IDENT:
                if (ch_term(c))
                begin
                    push_open(K_IDENT, gap(lx_off, lx_start));
                    lx_mode = M_IDLE;
                    begin_token(c);
                end
            M_ZERO:
                if (c == "x" || c == "X" || c == "b" || c == "B")
                begin
                    lx_start = up_sat(lx_off);
                    lx_mode = (c == "x" || c == "X") ? M_HEX : M_BIN;
                end
                else
                begin
                    lx_mode = M_DEC;
                    in_decimal(c);
                end
            M_DEC:
                in_decimal(c);
            M_DECDOT:
                if (c == ".")
                begin
                    // Range dots: the number ends before the first dot.
                    dot = down_sat(lx_off);
                    push_open((lx_dots > 1) ? K_DOUBLE : K_INT, gap(dot, lx_start));
                    push_token(1'b1, K_OP, dot, 1, lx_line, down_sat(lx_col), E_NONE);
                    lx_mode = M_IDLE;
                    begin_token(c);
                end
                else if (lx_dots > 1)
                    raise_error(E_DOTS);
                else
                begin
                    lx_mode = M_DEC;
                    in_decimal(c);
                end
            M_FLOATEND:
            begin
                lx_mode = M_IDLE;
                if (ch_term(c))
                    begin_token(c);
                else
                    raise_error(E_JUNK);
            end
            M_HEX:
                if (!ch_hex(c))
                    close_number(K_HEX, c);
            M_BIN:
                if (c != "0" && c != "1")
                    close_number(K_BIN, c);
            M_STRING:
                if (c == 8'h0A || c == 8'h00)
                    raise_error(E_STRING);
                else if (c == (lx_dq ? 8'h22 : 8'h27) && !lx_esc)
                begin
                    push_open(lx_dq ? K_STRING : K_CHAR, gap(lx_off, lx_start));
                    lx_mode = M_IDLE;
                end
                else
                    lx_esc = (c == 8'h5C) ? ~lx_esc : 1'b0;
            M_LINECMT:
                if (c == 8'h0A)
                begin
                    push_open(K_LCMT, gap(lx_off, lx_start));
                    lx_mode = M_IDLE;
                end
            M_BLOCKCMT:
                // A repeated star keeps the closing pair half matched.
                if (lx_close == 1 && c == "/")
                begin
                    push_open(K_BCMT, gap(down_sat(lx_off), lx_start));
                    lx_close = 0;
                    lx_mode = M_IDLE;
                end
                else
                    lx_close = (c == "*") ? 2'd1 : 2'd0;
            default:
            begin
                lx_mode = M_IDLE;
                begin_token(c);
            end
        endcase
    endtask

    // Flush of the open token at the end of a source.
    task automatic flush_source();
        pos_t len;
        len = gap(up_sat(lx_off), lx_start);
        if (lx_slash)
            push_open(K_OP, 1);
        case (lx_mode)
            M_IDENT:    push_open(K_IDENT, len);
            M_ZERO,
            M_DEC:      push_open((lx_dots != 0) ? K_DOUBLE : K_INT, len);
            M_DECDOT:
                if (lx_dots > 1)
                    raise_error(E_DOTS);
                else
                    push_open(K_DOUBLE, len);
            M_HEX:      push_open(K_HEX, len);
            M_BIN:      push_open(K_BIN, len);
            M_LINECMT:  push_open(K_LCMT, len);
            M_BLOCKCMT: raise_error(E_COMMENT);
            M_STRING:   raise_error(E_STRING);
            default:    ;
        endcase
    endtask

    task automatic predict_byte(logic [7:0] c, logic eos);
        int base;
        base = token_q.size();
        lx_nres = 0;
        if (!lx_err)
        begin
            lex_byte(c);
            if (eos && !lx_err)
                flush_source();
            lx_off = up_sat(lx_off);
            if (c == 8'h0A)
            begin
                lx_line = up_sat(lx_line);
                lx_col = 1;
            end
            else
                lx_col = up_sat(lx_col);
        end
        if (eos)
            clear_lexer();
        if (token_q.size() > base)
            token_q[token_q.size() - 1].last = 1'b1;
    endtask

    // Stimulus helpers.
    task automatic add_byte(logic [7:0] c);
        src_byte_t b;
        b.code = c;
        b.eos = 1'b0;
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic end_source();
        if (pending_bytes.size() == 0 || pending_bytes[$].eos)
            add_byte(" ");
        pending_bytes[$].eos = 1'b1;
        sources++;
    endtask

    task automatic add_fragment();
        string pool;
        case ($urandom_range(0, 15))
            0:  add_text("ab_9");
            1:  add_text("123");
            2:  add_text("4.75");
            3:  add_text("3.5f");
            4:  add_text("0x1aF");
            5:  add_text("0b1011");
            6:  add_text("5..9");
            7:  add_text("\"q\\\"w\\\\\"");
            8:  add_text("'z'");
            9:  add_text("// note\n");
            10: add_text("/* a ** b */");
            11:
            begin
                pool = "+-*/%^<=>?@~|!&.{}()[],;";
                add_byte(pool[$urandom_range(0, pool.len() - 1)]);
            end
            12: add_byte(8'($urandom_range(0, 255)));
            13: add_text($urandom_range(0, 1) ? "\n" : "\t");
            14: add_text($urandom_range(0, 1) ? "1.2.3" : "77q");
            default: add_text(" ");
        endcase
        if ($urandom_range(0, 2) != 0)
            add_byte(" ");
    endtask

    initial
    begin
        errors = 0;
        sources = 0;
        clear_lexer();
        // Directed sources: every token kind, range dots, slash at end.
        add_text("ab_1 + (x)[y]{z};,\n0x1F 0b101 12 3.5 2.5f 7..8 'c' \"s\\\"t\" // hi\n");
        add_text("/* a**/ /");
        end_source();
        add_text("1.2.3");   end_source();
        add_text("12a");     end_source();
        add_text("\"ab\n");  end_source();
        add_text("/* x");    end_source();
        add_text("1.5fz");   end_source();
        add_text("9.");      end_source();
        add_text("'o");      end_source();
        add_byte(8'h00); add_text(" \"a"); add_byte(8'h00); end_source();
        add_byte(8'hFF); add_text(" 0 0xg"); end_source();
        // One short random source of token fragments.
        repeat (2)
            add_fragment();
        end_source();
    end

    // Reset and reset-time drive values.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Input monitor: predict each accepted byte.
    always @(posedge clk)
    begin
        byte_taken <= 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_byte(s_tdata, s_tlast);
            byte_taken <= 1'b1;
        end
    end

    // Driver: idle rates change by phase; one pause waits for all results.
    always @(negedge clk)
    begin
        int idle_in, idle_out;
        if (rst_n)
        begin
            idle_in = (sent < 40) ? 17 : (sent < 80) ? 46 : 0;
            idle_out = (sent < 40) ? 46 : (sent < 80) ? 17 : 0;
            m_tready <= ($urandom_range(0, 99) >= idle_out);
            if (!s_tvalid || byte_taken)
            begin
                if (pending_bytes.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
                else if (sent == 60 && !paused && token_q.size() != 0)
                    s_tvalid <= 1'b0;
                else if ($urandom_range(0, 99) < idle_in)
                    s_tvalid <= 1'b0;
                else
                begin
                    if (sent == 60)
                        paused <= 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_bytes[0].code;
                    s_tlast <= pending_bytes[0].eos;
                    pending_bytes.pop_front();
                    sent <= sent + 1;
                end
            end
        end
    end

    // Output monitor: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        token_t exp_t, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser[0], m_tuser[4:1], m_tdata[15:0], m_tdata[31:16],
                    m_tdata[47:32], m_tdata[63:48], m_tdata[66:64], m_tlast};
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                $display("%0t: unexpected result valid=%0d kind=%0d start=%0d err=%0d",
                         $time, got.valid, got.kind, got.start, got.err);
                errors++;
            end
            else
            begin
                exp_t = token_q.pop_front();
                if (got != exp_t)
                begin
                    $display("%0t: mismatch expected v%0d k%0d s%0d n%0d l%0d c%0d e%0d t%0d",
                             $time, exp_t.valid, exp_t.kind, exp_t.start, exp_t.length,
                             exp_t.line, exp_t.column, exp_t.err, exp_t.last);
                    $display("%0t:          actual   v%0d k%0d s%0d n%0d l%0d c%0d e%0d t%0d",
                             $time, got.valid, got.kind, got.start, got.length,
                             got.line, got.column, got.err, got.last);
                    errors++;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        sent = 0;
        tokens_seen = 0;
        stim_done = 0;
        paused = 0;
        byte_taken = 0;
        wait (stim_done && !s_tvalid && token_q.size() == 0);
        repeat (10) @(posedge clk);
        if (token_q.size() != 0)
            errors++;
        $display("Ran %0d sources, %0d bytes, %0d results checked, under both idle mixes",
                 sources, sent, tokens_seen);
        $display("and one full drain of the results; %0d failures.", errors);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
